// ===== rtl/fdc_pkg.sv =====
// ----------------------------------------------------------------------------
// fdc_pkg
// Types, codes and the byte-wide CRC16-XMODEM update for the frame deframer.
// ----------------------------------------------------------------------------
package fdc_pkg;

  localparam logic [7:0]  StartByteRst = 8'hA5;
  localparam logic [15:0] CrcPoly      = 16'h1021;

  typedef enum logic [5:0] {
    PH_HUNT    = 6'b000001,
    PH_LEN_LO  = 6'b000010,
    PH_LEN_HI  = 6'b000100,
    PH_PAYLOAD = 6'b001000,
    PH_CRC_LO  = 6'b010000,
    PH_CRC_HI  = 6'b100000
  } phase_t;

  typedef struct packed {
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic [9:0]  payload_index;
    logic        length_rejected;
    logic        frame_done;
    logic        frame_good;
    logic [10:0] frame_length;
  } res_t;

  // MSB-first, no reflection, no final xor
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {data, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== rtl/fdc_rx_fsm.sv =====
// ----------------------------------------------------------------------------
// fdc_rx_fsm
// Receiver state machine: hunt, length, payload, CRC; running CRC per byte.
// ----------------------------------------------------------------------------
module fdc_rx_fsm #(
  parameter int MAX_PAYLOAD = 1024
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          step,
  input  logic [7:0]    rx_data,
  input  logic [7:0]    start_byte,
  output fdc_pkg::res_t res
);

  localparam int          CntW   = (MAX_PAYLOAD < 2) ? 1 : $clog2(MAX_PAYLOAD + 1);
  localparam logic [15:0] MaxLen = 16'(MAX_PAYLOAD);

  fdc_pkg::phase_t phase_r, phase_nxt;
  logic [15:0]     len_r, len_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic [15:0]     crc_r, crc_nxt;
  logic [7:0]      crclo_r, crclo_nxt;

  logic [15:0]     crc_upd;
  logic [15:0]     len_full;
  logic [CntW-1:0] cnt_inc;
  logic [15:0]     cnt_wide;

  assign crc_upd  = fdc_pkg::crc_byte(crc_r, rx_data);
  assign len_full = {rx_data, len_r[7:0]};
  assign cnt_inc  = cnt_r + CntW'(1);
  assign cnt_wide = 16'(cnt_r);

  always_comb begin
    phase_nxt = phase_r;
    len_nxt   = len_r;
    cnt_nxt   = cnt_r;
    crc_nxt   = crc_r;
    crclo_nxt = crclo_r;
    res       = '0;
    unique case (phase_r)
      fdc_pkg::PH_HUNT: begin
        if (rx_data == start_byte) begin
          crc_nxt   = '0;
          phase_nxt = fdc_pkg::PH_LEN_LO;
        end
      end
      fdc_pkg::PH_LEN_LO: begin
        len_nxt   = {8'h00, rx_data};
        crc_nxt   = crc_upd;
        phase_nxt = fdc_pkg::PH_LEN_HI;
      end
      fdc_pkg::PH_LEN_HI: begin
        if (len_full > MaxLen) begin
          res.length_rejected = 1'b1;
          phase_nxt = fdc_pkg::PH_HUNT;
          len_nxt   = '0;
          cnt_nxt   = '0;
          crc_nxt   = '0;
          crclo_nxt = '0;
        end else begin
          len_nxt   = len_full;
          crc_nxt   = crc_upd;
          cnt_nxt   = '0;
          phase_nxt = (len_full != 16'h0000) ? fdc_pkg::PH_PAYLOAD : fdc_pkg::PH_CRC_LO;
        end
      end
      fdc_pkg::PH_PAYLOAD: begin
        res.payload_valid = 1'b1;
        res.payload_byte  = rx_data;
        res.payload_index = cnt_wide[9:0];
        crc_nxt = crc_upd;
        cnt_nxt = cnt_inc;
        if (16'(cnt_inc) >= len_r) begin
          phase_nxt = fdc_pkg::PH_CRC_LO;
        end
      end
      fdc_pkg::PH_CRC_LO: begin
        crclo_nxt = rx_data;
        phase_nxt = fdc_pkg::PH_CRC_HI;
      end
      fdc_pkg::PH_CRC_HI: begin
        res.frame_done   = 1'b1;
        res.frame_good   = ({rx_data, crclo_r} == crc_r);
        res.frame_length = len_r[10:0];
        phase_nxt = fdc_pkg::PH_HUNT;
        len_nxt   = '0;
        cnt_nxt   = '0;
        crc_nxt   = '0;
        crclo_nxt = '0;
      end
      default: begin
        phase_nxt = fdc_pkg::PH_HUNT;
        len_nxt   = '0;
        cnt_nxt   = '0;
        crc_nxt   = '0;
        crclo_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= fdc_pkg::PH_HUNT;
      len_r   <= '0;
      cnt_r   <= '0;
      crc_r   <= '0;
      crclo_r <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      len_r   <= len_nxt;
      cnt_r   <= cnt_nxt;
      crc_r   <= crc_nxt;
      crclo_r <= crclo_nxt;
    end
  end

endmodule

// ===== rtl/frame_deframer_crc16.sv =====
// ----------------------------------------------------------------------------
// frame_deframer_crc16
// Length-prefixed frame receiver with running CRC16-XMODEM check.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_stall carry one received byte per transfer (in_rx_data).
//   out_valid/out_stall carry exactly one result per input byte, in order:
//   payload byte and index, length reject, frame done/good and length.
//   cfg_valid/cfg_ready write the start byte; cfg_ready is always high.
//   Write it only while no bytes are in flight.
//   A taken byte passes two register stages in order: the input register,
//   then the result register, which drives the out_ ports.
//   Throughput: one byte per cycle while the output is not stalled; the CRC
//   byte update and the state step are combinational between the two registers.
//   Reset: receiver hunts for the start byte, start byte returns to 0xA5,
//   both stages empty.
//   Out stall: the result register holds; the input register holds its byte
//   and in_stall rises once both stages are full.
// ----------------------------------------------------------------------------
module frame_deframer_crc16 #(
  parameter int MAX_PAYLOAD = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_payload_valid,
  output logic [7:0]  out_payload_byte,
  output logic [9:0]  out_payload_index,
  output logic        out_length_rejected,
  output logic        out_frame_done,
  output logic        out_frame_good,
  output logic [10:0] out_frame_length,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);

  logic          s1_valid_r;
  logic [7:0]    s1_data_r;
  logic          out_valid_r;
  fdc_pkg::res_t res_r;
  fdc_pkg::res_t res_nxt;
  logic [7:0]    start_byte_r;
  logic          out_free;
  logic          step;

  assign out_free  = !out_valid_r || !out_stall;
  assign step      = s1_valid_r && out_free;
  assign in_stall  = s1_valid_r && !out_free;
  assign cfg_ready = 1'b1;

  fdc_rx_fsm #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_fsm (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .rx_data   (s1_data_r),
    .start_byte(start_byte_r),
    .res       (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_byte_r <= fdc_pkg::StartByteRst;
    end else if (cfg_valid && cfg_ready) begin
      start_byte_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_data_r <= in_rx_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_payload_valid   = res_r.payload_valid;
  assign out_payload_byte    = res_r.payload_byte;
  assign out_payload_index   = res_r.payload_index;
  assign out_length_rejected = res_r.length_rejected;
  assign out_frame_done      = res_r.frame_done;
  assign out_frame_good      = res_r.frame_good;
  assign out_frame_length    = res_r.frame_length;

`ifndef SYNTHESIS
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("input stalled without a full pipeline");

  a_stage_advances: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> out_valid_r)
    else $error("advanced byte did not reach the result register");

  a_good_needs_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_frame_good) |-> out_frame_done)
    else $error("frame_good without frame_done");

  a_result_kinds_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot0({out_payload_valid, out_length_rejected, out_frame_done}))
    else $error("more than one result kind in one transfer");
`endif

endmodule

// ===== dv/tb_frame_deframer_crc16.sv =====
// ----------------------------------------------------------------------------
// tb_frame_deframer_crc16
// Self-checking bench for the length-prefixed CRC16 frame receiver. A short
// directed table checks hunting, oversize and zero lengths, bad and good CRC
// and payload indexing. After it come random frame streams under several start
// bytes and idle patterns, each checked against a cycle-free deframer model.
// ----------------------------------------------------------------------------
module tb_frame_deframer_crc16;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_LEN     = 1024;
  localparam int STUCK_LIMIT = 2000;
  localparam int MAX_REPORTS = 10;

  typedef enum logic [1:0] {
    SEND_BYTE,
    SEND_CRC_LO,
    SEND_CRC_HI
  } row_kind_t;

  typedef struct packed {
    row_kind_t      kind;
    logic [7:0]     data;
    logic           typed;
    fdc_pkg::res_t  want;
  } dir_row_t;

  localparam fdc_pkg::res_t RES_QUIET      = '0;
  localparam fdc_pkg::res_t RES_REJECT     = '{1'b0, 8'h00, 10'd0, 1'b1, 1'b0, 1'b0, 11'd0};
  localparam fdc_pkg::res_t RES_GOOD_EMPTY = '{1'b0, 8'h00, 10'd0, 1'b0, 1'b1, 1'b1, 11'd0};
  localparam fdc_pkg::res_t RES_BAD_EMPTY  = '{1'b0, 8'h00, 10'd0, 1'b0, 1'b1, 1'b0, 11'd0};
  localparam fdc_pkg::res_t RES_PAY_FIRST  = '{1'b1, 8'h00, 10'd0, 1'b0, 1'b0, 1'b0, 11'd0};
  localparam fdc_pkg::res_t RES_PAY_SECOND = '{1'b1, 8'hFF, 10'd1, 1'b0, 1'b0, 1'b0, 11'd0};

  // start byte is the reset value 0xA5 throughout
  localparam dir_row_t DIR_ROWS [25] = '{
    '{SEND_BYTE,   8'h00, 1'b1, RES_QUIET},       // noise while hunting
    '{SEND_BYTE,   8'hFF, 1'b1, RES_QUIET},
    '{SEND_BYTE,   8'hA5, 1'b1, RES_QUIET},
    '{SEND_BYTE,   8'h01, 1'b1, RES_QUIET},
    '{SEND_BYTE,   8'h04, 1'b1, RES_REJECT},      // length one above limit
    '{SEND_BYTE,   8'hA5, 1'b1, RES_QUIET},
    '{SEND_BYTE,   8'hFF, 1'b1, RES_QUIET},
    '{SEND_BYTE,   8'hFF, 1'b1, RES_REJECT},      // largest length
    '{SEND_BYTE,   8'hA5, 1'b1, RES_QUIET},
    '{SEND_BYTE,   8'h00, 1'b1, RES_QUIET},
    '{SEND_BYTE,   8'h00, 1'b1, RES_QUIET},       // empty frame
    '{SEND_BYTE,   8'h00, 1'b1, RES_QUIET},
    '{SEND_BYTE,   8'h00, 1'b1, RES_GOOD_EMPTY},
    '{SEND_BYTE,   8'hA5, 1'b1, RES_QUIET},
    '{SEND_BYTE,   8'h00, 1'b1, RES_QUIET},
    '{SEND_BYTE,   8'h00, 1'b1, RES_QUIET},
    '{SEND_BYTE,   8'hFF, 1'b1, RES_QUIET},
    '{SEND_BYTE,   8'hFF, 1'b1, RES_BAD_EMPTY},   // wrong checksum
    '{SEND_BYTE,   8'hA5, 1'b1, RES_QUIET},
    '{SEND_BYTE,   8'h02, 1'b1, RES_QUIET},
    '{SEND_BYTE,   8'h00, 1'b1, RES_QUIET},
    '{SEND_BYTE,   8'h00, 1'b1, RES_PAY_FIRST},
    '{SEND_BYTE,   8'hFF, 1'b1, RES_PAY_SECOND},
    '{SEND_CRC_LO, 8'h00, 1'b0, RES_QUIET},
    '{SEND_CRC_HI, 8'h00, 1'b0, RES_QUIET}
  };

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_rx_data;
  logic        out_valid;
  logic        out_stall;
  logic        out_payload_valid;
  logic [7:0]  out_payload_byte;
  logic [9:0]  out_payload_index;
  logic        out_length_rejected;
  logic        out_frame_done;
  logic        out_frame_good;
  logic [10:0] out_frame_length;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_data;

  // deframer model state
  fdc_pkg::phase_t rx_phase;
  logic [7:0]  pr_start;
  logic [15:0] pr_len;
  logic [15:0] pr_count;
  logic [15:0] pr_crc;
  logic [7:0]  pr_crc_lo;

  fdc_pkg::res_t awaited_res [$];
  fdc_pkg::res_t got_res;
  fdc_pkg::res_t want_res;
  int          idle_mode;
  int          n_err;
  int          n_results;
  int          n_bytes;
  int          n_good;
  int          n_bad;
  int          n_reject;
  int          n_payload;
  int          n_starts;
  int          stuck_cycles;

  frame_deframer_crc16 #(
    .MAX_PAYLOAD(MAX_LEN)
  ) uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_rx_data         (in_rx_data),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_payload_valid  (out_payload_valid),
    .out_payload_byte   (out_payload_byte),
    .out_payload_index  (out_payload_index),
    .out_length_rejected(out_length_rejected),
    .out_frame_done     (out_frame_done),
    .out_frame_good     (out_frame_good),
    .out_frame_length   (out_frame_length),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_data           (cfg_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic logic [15:0] crc_next(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int k = 7; k >= 0; k--) begin
      fb = c[15] ^ b[k];
      c  = {c[14:0], 1'b0} ^ (fb ? fdc_pkg::CrcPoly : 16'h0000);
    end
    return c;
  endfunction

  function automatic void rx_clear();
    rx_phase  = fdc_pkg::PH_HUNT;
    pr_len    = '0;
    pr_count  = '0;
    pr_crc    = '0;
    pr_crc_lo = '0;
  endfunction

  function automatic fdc_pkg::res_t deframe_byte(input logic [7:0] b);
    fdc_pkg::res_t r;
    r = '0;
    case (rx_phase)
      fdc_pkg::PH_HUNT: begin
        if (b == pr_start) begin
          pr_crc   = '0;
          rx_phase = fdc_pkg::PH_LEN_LO;
        end
      end
      fdc_pkg::PH_LEN_LO: begin
        pr_len   = {8'h00, b};
        pr_crc   = crc_next(pr_crc, b);
        rx_phase = fdc_pkg::PH_LEN_HI;
      end
      fdc_pkg::PH_LEN_HI: begin
        pr_len[15:8] = b;
        pr_crc       = crc_next(pr_crc, b);
        if (pr_len > MAX_LEN) begin
          r.length_rejected = 1'b1;
          rx_clear();
        end else begin
          pr_count = '0;
          rx_phase = (pr_len == 0) ? fdc_pkg::PH_CRC_LO : fdc_pkg::PH_PAYLOAD;
        end
      end
      fdc_pkg::PH_PAYLOAD: begin
        r.payload_valid = 1'b1;
        r.payload_byte  = b;
        r.payload_index = pr_count[9:0];
        pr_crc          = crc_next(pr_crc, b);
        pr_count        = pr_count + 16'd1;
        if (pr_count >= pr_len) begin
          rx_phase = fdc_pkg::PH_CRC_LO;
        end
      end
      fdc_pkg::PH_CRC_LO: begin
        pr_crc_lo = b;
        rx_phase  = fdc_pkg::PH_CRC_HI;
      end
      fdc_pkg::PH_CRC_HI: begin
        r.frame_done   = 1'b1;
        r.frame_good   = ({b, pr_crc_lo} == pr_crc);
        r.frame_length = pr_len[10:0];
        rx_clear();
      end
      default: begin
        rx_clear();
      end
    endcase
    return r;
  endfunction

  // mode 0: never idle, 1: light, 2: heavy
  function automatic int pause_len();
    int r;
    r = $urandom_range(0, 99);
    if (idle_mode == 0 || r < (idle_mode == 1 ? 75 : 40)) begin
      return 0;
    end
    return (r < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40);
  endfunction

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic xfer_byte(input logic [7:0] b, input logic typed = 1'b0,
                           input fdc_pkg::res_t typed_res = '0);
    int            gap;
    fdc_pkg::res_t r;
    gap = pause_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_data <= b;
    do @(posedge clk); while (in_stall);
    r = deframe_byte(b);
    awaited_res.push_back(typed ? typed_res : r);
    n_bytes++;
    n_good    += int'(r.frame_done && r.frame_good);
    n_bad     += int'(r.frame_done && !r.frame_good);
    n_reject  += int'(r.length_rejected);
    n_payload += int'(r.payload_valid);
    @(negedge clk);
  endtask

  // called at a falling edge
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (awaited_res.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_start(input logic [7:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    pr_start = v;
    n_starts++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // cut > 0 drops the frame after that many payload bytes
  task automatic send_frame(input int unsigned len, input bit bad_crc, input int unsigned cut);
    logic [15:0] crc_word;
    logic [15:0] len_word;
    len_word = len[15:0];
    xfer_byte(pr_start);
    xfer_byte(len_word[7:0]);
    xfer_byte(len_word[15:8]);
    if (len > MAX_LEN) begin
      return;
    end
    for (int unsigned i = 0; i < len; i++) begin
      if (cut != 0 && i == cut) begin
        return;
      end
      xfer_byte(8'($urandom_range(0, 255)));
    end
    crc_word = pr_crc;
    if (bad_crc) begin
      crc_word ^= 16'h0001 << $urandom_range(0, 15);
    end
    xfer_byte(crc_word[7:0]);
    xfer_byte(crc_word[15:8]);
  endtask

  task automatic run_random(input logic [7:0] sb, input int mode, input int n_items,
                            input bit with_max);
    int          stop_at;
    int          r;
    int unsigned len;
    wait_drained();
    write_start(sb);
    idle_mode = mode;
    stop_at   = n_bytes + n_items;
    if (with_max) begin
      send_frame(MAX_LEN, 1'b0, 0);
    end
    while (n_bytes < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        repeat ($urandom_range(1, 4)) xfer_byte(8'($urandom_range(0, 255)));
      end else if (r < 13) begin
        send_frame($urandom_range(MAX_LEN + 1, 65535), 1'b0, 0);
      end else if (r < 16) begin
        len = $urandom_range(2, 16);
        send_frame(len, 1'b0, $urandom_range(1, len - 1));
      end else begin
        r = $urandom_range(0, 99);
        if (r < 5) begin
          len = 0;
        end else if (r < 70) begin
          len = $urandom_range(1, 8);
        end else if (r < 95) begin
          len = $urandom_range(9, 64);
        end else begin
          len = $urandom_range(65, 300);
        end
        send_frame(len, $urandom_range(0, 99) < 15, 0);
      end
    end
  endtask

  task automatic check_field(input string fname, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      if (n_err < MAX_REPORTS) begin
        $display("MISMATCH result %0d %s: expected 0x%0h, got 0x%0h",
                 n_results, fname, want, got);
      end
      n_err++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      got_res = {out_payload_valid, out_payload_byte, out_payload_index,
                 out_length_rejected, out_frame_done, out_frame_good, out_frame_length};
      if (awaited_res.size() == 0) begin
        if (n_err < MAX_REPORTS) begin
          $display("MISMATCH result %0d arrived with none outstanding", n_results);
        end
        n_err++;
      end else begin
        want_res = awaited_res.pop_front();
        check_field("payload_valid", 16'(want_res.payload_valid),
                    16'(got_res.payload_valid));
        check_field("payload_byte", 16'(want_res.payload_byte),
                    16'(got_res.payload_byte));
        check_field("payload_index", 16'(want_res.payload_index),
                    16'(got_res.payload_index));
        check_field("length_rejected", 16'(want_res.length_rejected),
                    16'(got_res.length_rejected));
        check_field("frame_done", 16'(want_res.frame_done),
                    16'(got_res.frame_done));
        check_field("frame_good", 16'(want_res.frame_good),
                    16'(got_res.frame_good));
        check_field("frame_length", 16'(want_res.frame_length),
                    16'(got_res.frame_length));
      end
      n_results++;
    end
  end

  always begin
    int n;
    @(negedge clk);
    n = pause_len();
    if (n > 0) begin
      out_stall <= 1'b1;
      repeat (n) @(negedge clk);
    end
    out_stall <= 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (stuck_cycles == STUCK_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles", STUCK_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    logic [7:0] b;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_rx_data   = '0;
    cfg_valid    = 1'b0;
    cfg_data     = '0;
    idle_mode    = 1;
    n_bytes      = 0;
    n_good       = 0;
    n_bad        = 0;
    n_reject     = 0;
    n_payload    = 0;
    n_starts     = 0;
    pr_start     = fdc_pkg::StartByteRst;
    rx_clear();

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (DIR_ROWS[i]) begin
      case (DIR_ROWS[i].kind)
        SEND_CRC_LO: b = pr_crc[7:0];
        SEND_CRC_HI: b = pr_crc[15:8];
        default:     b = DIR_ROWS[i].data;
      endcase
      xfer_byte(b, DIR_ROWS[i].typed, DIR_ROWS[i].want);
    end

    run_random(8'h00, 1, 300, 1'b0);
    run_random(8'hFF, 2, 1300, 1'b1);
    run_random(8'($urandom_range(1, 254)), 0, 300, 1'b0);
    run_random(fdc_pkg::StartByteRst, 1, 300, 1'b0);

    wait_drained();
    repeat (4) @(posedge clk);

    $display("Sent %0d bytes under %0d start byte settings; %0d results checked",
             n_bytes, n_starts, n_results);
    $display("Frames: %0d good, %0d bad CRC, %0d length rejects, %0d payload bytes",
             n_good, n_bad, n_reject, n_payload);
    if (n_err == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches", n_err);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/fdc_pkg.sv
rtl/fdc_rx_fsm.sv
rtl/frame_deframer_crc16.sv
dv/tb_frame_deframer_crc16.sv
